@@ rtl/core/slpbm_pkg.sv @@
// Shared types and constants for the serial-loaded PRG bank mapper.
package slpbm_pkg;

    // Result kinds.
    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_ROM  = 2'd1;
    localparam logic [1:0] KIND_RAM  = 2'd2;
    localparam logic [1:0] KIND_32K  = 2'd3;

    // Access kinds.
    localparam logic REQ_READ  = 1'b0;
    localparam logic REQ_WRITE = 1'b1;

    // Serial port register targets, chosen by address bits 14:13.
    localparam logic [1:0] SEL_CONTROL = 2'd0;
    localparam logic [1:0] SEL_PRG     = 2'd3;

    // Shift register length and control values.
    localparam logic [2:0] SHIFT_LEN           = 3'd5;
    localparam logic [4:0] CONTROL_FORCE       = 5'h0C;
    localparam logic [4:0] CONTROL_RESET       = 5'h0C;
    localparam logic [3:0] PRG_LAST_BANK_RESET = 4'hF;

    // Address regions (upper three address bits).
    localparam logic [2:0] REGION_PRG_RAM = 3'b011;

    // One bus access.
    typedef struct packed {
        logic        req_type;
        logic [15:0] addr;
        logic [7:0]  wdata;
    } req_t;

    // One result.
    typedef struct packed {
        logic [1:0]  kind;
        logic [17:0] rom_addr;
        logic [12:0] ram_addr;
        logic [7:0]  ram_data;
    } rsp_t;

endpackage

@@ rtl/core/serial_loaded_prg_bank_mapper_core.sv @@
// Top level of the serial-loaded PRG bank mapper: handshakes, pipeline registers and config.
// Pipeline: an accepted item passes through the input register, then the result register.
// Throughput: one item per cycle; the input stalls only when both registers are full and the
// output is stalled.
// Reset (rst_n, asynchronous): pipeline empty, prg_last_bank 15, control 0x0C, other mapper state zero.
module serial_loaded_prg_bank_mapper_core
    import slpbm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        req_type,
    input  logic [15:0] addr,
    input  logic [7:0]  wdata,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  kind,
    output logic [17:0] rom_addr,
    output logic [12:0] ram_addr,
    output logic [7:0]  ram_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  prg_last_bank
);

    req_t       in_reg;
    logic       in_valid_reg;
    logic       in_valid_next;
    rsp_t       out_reg;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic [3:0] prg_last_bank_reg;
    rsp_t       rsp;
    logic       advance;
    logic       in_accept;
    logic       step;

    // Pipeline flow control.
    assign advance        = !out_valid_reg || !out_stall;
    assign in_stall       = in_valid_reg && !advance;
    assign in_accept      = in_valid && !in_stall;
    assign step           = advance && in_valid_reg;
    assign in_valid_next  = in_accept ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    assign out_valid_next = advance ? in_valid_reg : out_valid_reg;
    assign cfg_ready      = 1'b1;

    // Valid bits and configuration.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
            prg_last_bank_reg <= PRG_LAST_BANK_RESET;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
                prg_last_bank_reg <= prg_last_bank;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_accept)
            in_reg <= '{req_type: req_type, addr: addr, wdata: wdata};
        if (step)
            out_reg <= rsp;
    end

    // Mapper state and per-item logic.
    slpbm_mapper u_mapper (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (step),
        .req           (in_reg),
        .prg_last_bank (prg_last_bank_reg),
        .rsp           (rsp)
    );

    // Result outputs.
    assign out_valid = out_valid_reg;
    assign kind      = out_reg.kind;
    assign rom_addr  = out_reg.rom_addr;
    assign ram_addr  = out_reg.ram_addr;
    assign ram_data  = out_reg.ram_data;

    // The input stalls only when both pipeline registers hold items.
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> in_valid_reg && out_valid_reg && out_stall)
        else $error("input stalled with room in the pipeline");

    // Unused result fields stay zero.
    a_rom_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind != KIND_ROM |-> rom_addr == '0)
        else $error("ROM address set on a non-ROM result");

    a_ram_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind != KIND_RAM |-> ram_addr == '0 && ram_data == '0)
        else $error("RAM fields set on a non-RAM result");

endmodule

@@ rtl/core/slpbm_mapper.sv @@
// Mapper state (serial shift port, control, PRG select, bank windows) and per-access logic.
module slpbm_mapper
    import slpbm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  req_t       req,
    input  logic [3:0] prg_last_bank,
    output rsp_t       rsp
);

    logic [4:0] shift_value_reg;
    logic [4:0] shift_value_next;
    logic [2:0] bits_shifted_reg;
    logic [2:0] bits_shifted_next;
    logic [4:0] control_reg;
    logic [4:0] control_next;
    logic [4:0] prg_select_reg;
    logic [4:0] prg_select_next;
    logic [3:0] switched_bank_reg;
    logic [3:0] switched_bank_next;
    logic       fixed_is_low_reg;
    logic       fixed_is_low_next;

    logic [2:0] bits_inc;
    logic [3:0] bank;
    logic       remap;

    // Next state and result for the access at the head of the pipeline.
    always_comb
    begin
        shift_value_next   = shift_value_reg;
        bits_shifted_next  = bits_shifted_reg;
        control_next       = control_reg;
        prg_select_next    = prg_select_reg;
        switched_bank_next = switched_bank_reg;
        fixed_is_low_next  = fixed_is_low_reg;
        remap              = 1'b0;
        bits_inc           = bits_shifted_reg + 3'd1;
        bank               = (req.addr[14] == fixed_is_low_reg) ? switched_bank_reg
                                                                : prg_last_bank;
        rsp                = '0;

        if (req.req_type == REQ_READ)
        begin
            // ROM read through the two 16KB windows.
            if (req.addr[15])
            begin
                rsp.kind     = KIND_ROM;
                rsp.rom_addr = {bank, req.addr[13:0]};
            end
        end
        else if (req.addr[15])
        begin
            // Serial port write: reset or shift one bit in.
            if (req.wdata[7])
            begin
                shift_value_next  = '0;
                bits_shifted_next = '0;
                control_next      = control_reg | CONTROL_FORCE;
                remap             = 1'b1;
            end
            else
            begin
                shift_value_next  = {req.wdata[0], shift_value_reg[4:1]};
                bits_shifted_next = bits_inc;
                if (bits_inc >= SHIFT_LEN)
                begin
                    if (req.addr[14:13] == SEL_CONTROL)
                        control_next = shift_value_next;
                    else if (req.addr[14:13] == SEL_PRG)
                        prg_select_next = shift_value_next;
                    shift_value_next  = '0;
                    bits_shifted_next = '0;
                    remap             = 1'b1;
                end
            end

            // Recompute the mapping; 32KB mode keeps it and flags the item.
            if (remap)
            begin
                if (!control_next[3])
                    rsp.kind = KIND_32K;
                else
                begin
                    switched_bank_next = prg_select_next[3:0];
                    fixed_is_low_next  = ~control_next[2];
                end
            end
        end
        else if (req.addr[15:13] == REGION_PRG_RAM)
        begin
            // PRG RAM write.
            rsp.kind     = KIND_RAM;
            rsp.ram_addr = req.addr[12:0];
            rsp.ram_data = req.wdata;
        end
    end

    // State update when the access moves to the result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_value_reg   <= '0;
            bits_shifted_reg  <= '0;
            control_reg       <= CONTROL_RESET;
            prg_select_reg    <= '0;
            switched_bank_reg <= '0;
            fixed_is_low_reg  <= 1'b0;
        end
        else if (step)
        begin
            shift_value_reg   <= shift_value_next;
            bits_shifted_reg  <= bits_shifted_next;
            control_reg       <= control_next;
            prg_select_reg    <= prg_select_next;
            switched_bank_reg <= switched_bank_next;
            fixed_is_low_reg  <= fixed_is_low_next;
        end
    end

    // The bit counter never rests at a full shift.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        bits_shifted_reg < SHIFT_LEN)
        else $error("shift bit count out of range");

    // A completed shift always leaves the shift register empty.
    a_shift_clear: assert property (@(posedge clk) disable iff (!rst_n)
        step && req.req_type == REQ_WRITE && req.addr[15] && !req.wdata[7]
        && bits_inc >= SHIFT_LEN |=> shift_value_reg == '0 && bits_shifted_reg == '0)
        else $error("shift register not cleared after fifth bit");

    // The mapping changes only on a serial port write.
    a_map_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !(step && req.req_type == REQ_WRITE && req.addr[15])
        |=> $stable(switched_bank_reg) && $stable(fixed_is_low_reg))
        else $error("mapping changed without a serial port write");

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the serial-loaded PRG bank mapper core.
`timescale 1ns / 1ps

module tb_top;
    import slpbm_pkg::*;

    localparam int IDLE_LIMIT  = 1000;
    localparam int DRAIN_TICKS = 4;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        req_type = REQ_READ;
    logic [15:0] addr = '0;
    logic [7:0]  wdata = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  kind;
    logic [17:0] rom_addr;
    logic [12:0] ram_addr;
    logic [7:0]  ram_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [3:0]  last_bank_cfg = PRG_LAST_BANK_RESET;

    serial_loaded_prg_bank_mapper_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .req_type     (req_type),
        .addr         (addr),
        .wdata        (wdata),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .kind         (kind),
        .rom_addr     (rom_addr),
        .ram_addr     (ram_addr),
        .ram_data     (ram_data),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .prg_last_bank(last_bank_cfg)
    );

    // Bus accesses waiting to be sent, and mapped results still due from the core.
    req_t access_q[$];
    rsp_t mapped_q[$];

    // Mirror of the mapper state.
    logic [4:0] shift_acc;
    logic [2:0] shift_cnt;
    logic [4:0] ctrl_q;
    logic [4:0] prg_sel_q;
    logic [3:0] sw_bank;
    logic       fixed_low;
    logic [3:0] last_bank_m;

    int   mismatch_cnt = 0;
    int   idle_cycles = 0;
    logic in_accepted = 1'b0;
    int   gap_left = 0;
    int   snd_steady = 0;
    int   stall_left = 0;
    int   rcv_steady = 0;
    req_t nxt;
    rsp_t got;

    initial begin
        forever #5 clk = ~clk;
    end

    // Recompute the PRG windows; returns 1 when 32KB mode is requested.
    function automatic logic remap_windows();
        if (!ctrl_q[3])
            return 1'b1;
        sw_bank   = prg_sel_q[3:0];
        fixed_low = ~ctrl_q[2];
        return 1'b0;
    endfunction

    // Map one bus access and advance the mirrored state.
    function automatic rsp_t map_access(req_t r);
        rsp_t       res;
        logic [3:0] bank;
        logic       wide;
        res  = '0;
        wide = 1'b0;
        res.kind = KIND_NONE;
        if (r.req_type == REQ_READ) begin
            if (r.addr[15]) begin
                bank = (r.addr[14] == fixed_low) ? sw_bank : last_bank_m;
                res.kind = KIND_ROM;
                res.rom_addr = {bank, r.addr[13:0]};
            end
        end else if (r.addr[15]) begin
            if (r.wdata[7]) begin
                shift_acc = '0;
                shift_cnt = '0;
                ctrl_q = ctrl_q | CONTROL_FORCE;
                wide = remap_windows();
            end else begin
                shift_acc = {r.wdata[0], shift_acc[4:1]};
                shift_cnt = shift_cnt + 3'd1;
                if (shift_cnt == SHIFT_LEN) begin
                    if (r.addr[14:13] == SEL_CONTROL)
                        ctrl_q = shift_acc;
                    else if (r.addr[14:13] == SEL_PRG)
                        prg_sel_q = shift_acc;
                    shift_acc = '0;
                    shift_cnt = '0;
                    wide = remap_windows();
                end
            end
            if (wide)
                res.kind = KIND_32K;
        end else if (r.addr[15:13] == REGION_PRG_RAM) begin
            res.kind = KIND_RAM;
            res.ram_addr = r.addr[12:0];
            res.ram_data = r.wdata;
        end
        return res;
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned seen);
        if (want != seen) begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, seen);
            mismatch_cnt++;
        end
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Sender and receiver, both moving at the falling edge.
    always @(negedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            out_stall <= 1'b0;
        end else begin
            // A stalled item is held; otherwise send the next one after its gap.
            if (!(in_valid && !in_accepted)) begin
                if (gap_left != 0) begin
                    in_valid <= 1'b0;
                    gap_left--;
                end else if (access_q.size() != 0) begin
                    nxt = access_q.pop_front();
                    in_valid <= 1'b1;
                    req_type <= nxt.req_type;
                    addr <= nxt.addr;
                    wdata <= nxt.wdata;
                    if (snd_steady != 0)
                        snd_steady--;
                    else if ($urandom_range(0, 99) < 2)
                        snd_steady = $urandom_range(20, 80);
                    else
                        gap_left = pick_gap();
                end else begin
                    in_valid <= 1'b0;
                end
            end

            // Receiver stalls come in runs, with stall-free stretches.
            if (stall_left != 0) begin
                out_stall <= 1'b1;
                stall_left--;
            end else begin
                out_stall <= 1'b0;
                if (rcv_steady != 0)
                    rcv_steady--;
                else if ($urandom_range(0, 99) < 2)
                    rcv_steady = $urandom_range(20, 80);
                else if ($urandom_range(0, 99) < 30)
                    stall_left = pick_gap() + 1;
            end
        end
    end

    // Handshakes are observed at the rising edge.
    always @(posedge clk) begin
        if (!rst_n) begin
            in_accepted <= 1'b0;
        end else begin
            in_accepted <= in_valid && !in_stall;

            if (cfg_valid && cfg_ready)
                last_bank_m = last_bank_cfg;

            // Compare each delivered result with the oldest one due.
            if (out_valid && !out_stall) begin
                if (mapped_q.size() == 0) begin
                    $display("%0t: result with nothing due, actual kind %0d rom 0x%0h",
                             $time, kind, rom_addr);
                    mismatch_cnt++;
                end else begin
                    got = mapped_q.pop_front();
                    check_field("kind", got.kind, kind);
                    check_field("rom_addr", got.rom_addr, rom_addr);
                    check_field("ram_addr", got.ram_addr, ram_addr);
                    check_field("ram_data", got.ram_data, ram_data);
                end
            end

            if (in_valid && !in_stall)
                mapped_q = {mapped_q, map_access('{req_type, addr, wdata})};

            if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;

            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
                $display("Verification failed");
                $finish;
            end
        end
    end

    task automatic push_access(logic t, logic [15:0] a, logic [7:0] d);
        req_t r;
        r.req_type = t;
        r.addr = a;
        r.wdata = d;
        access_q = {access_q, r};
    endtask

    // Five serial writes, LSB first; the last one picks the target register.
    task automatic push_serial(logic [1:0] sel, logic [4:0] val);
        logic [15:0] a;
        logic [7:0]  d;
        for (int i = 0; i < 5; i++) begin
            a = 16'h8000 | 16'($urandom_range(0, 16'h7FFF));
            if (i == 4)
                a[14:13] = sel;
            d = 8'($urandom_range(0, 255));
            d[7] = 1'b0;
            d[0] = val[i];
            push_access(REQ_WRITE, a, d);
        end
    endtask

    // Let every sent item come back, then give the pipeline time to settle.
    task automatic wait_idle();
        while (access_q.size() != 0 || in_valid || mapped_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_TICKS) @(negedge clk);
    endtask

    task automatic write_last_bank(logic [3:0] v);
        @(negedge clk);
        cfg_valid <= 1'b1;
        last_bank_cfg <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Random traffic, mostly complete serial loads mixed with reads and RAM writes.
    task automatic load_random(int quota);
        int          done;
        int          r;
        logic [1:0]  sel;
        logic [4:0]  v;
        logic [7:0]  d;
        done = 0;
        while (done < quota) begin
            r = $urandom_range(0, 99);
            if (r < 30) begin
                r = $urandom_range(0, 99);
                v = 5'($urandom_range(0, 31));
                if (r < 35) begin
                    sel = SEL_CONTROL;
                    if ($urandom_range(0, 99) < 80)
                        v[3] = 1'b1;
                end else if (r < 80) begin
                    sel = SEL_PRG;
                end else begin
                    sel = 2'($urandom_range(1, 2));
                end
                push_serial(sel, v);
                done += 5;
            end else if (r < 35) begin
                d = 8'($urandom_range(0, 255));
                d[7] = 1'b1;
                push_access(REQ_WRITE, 16'h8000 | 16'($urandom_range(0, 16'h7FFF)), d);
                done++;
            end else if (r < 40) begin
                // A stray serial bit that breaks up the next load.
                d = 8'($urandom_range(0, 255));
                d[7] = 1'b0;
                push_access(REQ_WRITE, 16'h8000 | 16'($urandom_range(0, 16'h7FFF)), d);
                done++;
            end else if (r < 75) begin
                push_access(REQ_READ, 16'h8000 | 16'($urandom_range(0, 16'h7FFF)),
                            8'($urandom_range(0, 255)));
                done++;
            end else if (r < 88) begin
                push_access(REQ_WRITE, 16'h6000 + 16'($urandom_range(0, 16'h1FFF)),
                            8'($urandom_range(0, 255)));
                done++;
            end else if (r < 94) begin
                push_access(REQ_READ, 16'($urandom_range(0, 16'h7FFF)),
                            8'($urandom_range(0, 255)));
                done++;
            end else begin
                push_access(REQ_WRITE, 16'($urandom_range(0, 16'h5FFF)),
                            8'($urandom_range(0, 255)));
                done++;
            end
        end
    endtask

    initial begin
        shift_acc = '0;
        shift_cnt = '0;
        ctrl_q = CONTROL_RESET;
        prg_sel_q = '0;
        sw_bank = '0;
        fixed_low = 1'b0;
        last_bank_m = PRG_LAST_BANK_RESET;

        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        // Window edges after reset, ignored accesses and the RAM range ends.
        push_access(REQ_READ, 16'h8000, 8'h00);
        push_access(REQ_READ, 16'hBFFF, 8'hFF);
        push_access(REQ_READ, 16'hC000, 8'h00);
        push_access(REQ_READ, 16'hFFFF, 8'hFF);
        push_access(REQ_READ, 16'h0000, 8'h00);
        push_access(REQ_READ, 16'h7FFF, 8'hFF);
        push_access(REQ_WRITE, 16'h5FFF, 8'hFF);
        push_access(REQ_WRITE, 16'h6000, 8'hFF);
        push_access(REQ_WRITE, 16'h7FFF, 8'h00);
        push_access(REQ_WRITE, 16'h8000, 8'h80);
        // Select bank 15, then swap the windows and read both.
        push_serial(SEL_PRG, 5'h1F);
        push_serial(SEL_CONTROL, 5'h08);
        push_access(REQ_READ, 16'h8000, 8'h00);
        push_access(REQ_READ, 16'hFFFF, 8'h00);
        // Control without bit 3 requests 32KB mode; a reset write clears it.
        push_serial(SEL_CONTROL, 5'h00);
        push_access(REQ_WRITE, 16'hFFFF, 8'hFF);
        wait_idle();

        // Bank limit at its low end: switched banks land beyond the cartridge.
        write_last_bank(4'h0);
        load_random(250);
        wait_idle();
        write_last_bank(4'hF);
        load_random(250);
        wait_idle();
        write_last_bank(4'h5);
        load_random(250);
        wait_idle();
        write_last_bank(4'($urandom_range(0, 15)));
        load_random(250);
        wait_idle();
        write_last_bank(4'hF);
        load_random(250);
        wait_idle();

        repeat (10) @(negedge clk);
        if (mismatch_cnt == 0 && mapped_q.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/slpbm_pkg.sv
rtl/core/slpbm_mapper.sv
rtl/core/serial_loaded_prg_bank_mapper_core.sv
tb/tb_top.sv
